// ----- rtl/template_store_running_average_learner_core_defines.svh -----
// Assertion macros, clocked on clk and disabled in reset.
`ifndef TEMPLATE_STORE_RUNNING_AVERAGE_LEARNER_CORE_DEFINES_SVH
`define TEMPLATE_STORE_RUNNING_AVERAGE_LEARNER_CORE_DEFINES_SVH

// Same-cycle implication.
`define TSRAL_ASSERT_IMP(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication.
`define TSRAL_ASSERT_NXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ----- rtl/tsral_pkg.sv -----
package tsral_pkg;

  localparam int CMD_W    = 2;
  localparam int BANK_FW  = 3;
  localparam int CLASS_FW = 4;
  localparam int PIX_FW   = 8;
  localparam int WEIGHT_W = 16;
  localparam int COUNT_W  = 5;

  localparam int BANKS_DEF   = 8;
  localparam int CLASSES_DEF = 10;
  localparam int PIXELS_DEF  = 256;

  localparam int ROM_PIX_W = 12;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX     = 16'hFFFF;
  localparam logic [WEIGHT_W-1:0] WEIGHT_CAP_RST = 16'd16;

  localparam logic [CMD_W-1:0] CMD_LEARN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd1;

  localparam int DIVIDEND_W = PIX_FW + WEIGHT_W;
  localparam int DIVISOR_W  = WEIGHT_W + 1;
  localparam int QUOT_W     = PIX_FW;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

  // Default template pixel of a class.
  function automatic logic [PIX_FW-1:0] rom_pixel(input logic [CLASS_FW-1:0] cls,
                                                 input logic [ROM_PIX_W-1:0] pix);
    logic [PIX_FW-1:0] c8;
    logic [PIX_FW-1:0] p8;
    logic [PIX_FW-1:0] h8;
    c8 = PIX_FW'(cls);
    p8 = pix[PIX_FW-1:0];
    h8 = pix[ROM_PIX_W-1:4];
    return PIX_FW'(c8 * 8'd29 + p8 * 8'd7 + h8 * 8'd13);
  endfunction

endpackage

// ----- rtl/tsral_if.sv -----
interface tsral_in_if;
  logic                            valid;
  logic                            ready;
  logic [tsral_pkg::CMD_W-1:0]     cmd;
  logic [tsral_pkg::BANK_FW-1:0]   bank;
  logic [tsral_pkg::CLASS_FW-1:0]  class_index;
  logic [tsral_pkg::PIX_FW-1:0]    pixel_index;
  logic [tsral_pkg::PIX_FW-1:0]    pixel_in;
  logic                            last_pixel;

  modport source (output valid, cmd, bank, class_index, pixel_index, pixel_in, last_pixel,
                  input ready);
  modport sink (input valid, cmd, bank, class_index, pixel_index, pixel_in, last_pixel,
                output ready);
endinterface

interface tsral_out_if;
  logic                            valid;
  logic                            ready;
  logic [tsral_pkg::PIX_FW-1:0]    pixel_out;
  logic [tsral_pkg::WEIGHT_W-1:0]  weight_out;
  logic [tsral_pkg::COUNT_W-1:0]   learned_count;
  logic                            status;

  modport source (output valid, pixel_out, weight_out, learned_count, status,
                  input ready);
  modport sink (input valid, pixel_out, weight_out, learned_count, status,
                output ready);
endinterface

interface tsral_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tsral_pkg::WEIGHT_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/template_store_running_average_learner_core.sv -----
// Template store with capped running-average learning. One transaction is taken at a time and
// its result waits in an output register, so the next transaction may be taken before the
// result is collected. A rejected address goes straight to the final state; a read or a learn
// into an unlearned class passes through the read and calculate states; a learn into a learned
// class also passes through the multiply and the 8-step restoring divider; a class reset
// sweeps the template back to its defaults through the single write port of the template RAM.
// While an earlier result is still uncollected, the final state of a transaction is held until
// the output register frees. After reset a clearing pass over all BANKS * CLASSES * PIXELS
// entries (20480 by default) loads every default template; no transaction is taken meanwhile,
// configuration writes are.
`include "template_store_running_average_learner_core_defines.svh"

module template_store_running_average_learner_core #(
  parameter int BANKS   = tsral_pkg::BANKS_DEF,
  parameter int CLASSES = tsral_pkg::CLASSES_DEF,
  parameter int PIXELS  = tsral_pkg::PIXELS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  tsral_cfg_if.sink   cfg,
  tsral_in_if.sink    item,
  tsral_out_if.source result
);
  import tsral_pkg::*;

  localparam int SLOTS  = BANKS * CLASSES;
  localparam int DEPTH  = SLOTS * PIXELS;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PIX_W  = $clog2(PIXELS);
  localparam int CLS_W  = $clog2(CLASSES);
  localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CALC  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_SWEEP = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]            state;
  logic [WEIGHT_W-1:0]   weight_cap;

  logic [CMD_W-1:0]      cmd_r;
  logic [BANK_FW-1:0]    bank_r;
  logic [CLASS_FW-1:0]   cls_r;
  logic [PIX_FW-1:0]     pix_r;
  logic [PIX_FW-1:0]     pin_r;
  logic                  last_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [ADDR_W-1:0]     addr_r;

  logic [ADDR_W-1:0]     addr_cnt;
  logic [PIX_W-1:0]      pix_cnt;
  logic [CLS_W-1:0]      cls_cnt;

  logic [SLOTS-1:0]      nz;
  logic [COUNT_W-1:0]    cnt [BANKS];
  logic [WEIGHT_W-1:0]   wmem [SLOTS];
  logic [WEIGHT_W-1:0]   wrd;
  logic                  w_we;
  logic [WEIGHT_W-1:0]   w_wdata;

  logic [DIVIDEND_W-1:0] prod;
  logic [DIVISOR_W-1:0]  dvs_r;

  logic [PIX_FW-1:0]     pend_pixel;
  logic [WEIGHT_W-1:0]   pend_weight;
  logic [COUNT_W-1:0]    pend_count;
  logic                  pend_status;

  logic                  res_valid;
  logic [PIX_FW-1:0]     res_pixel;
  logic [WEIGHT_W-1:0]   res_weight;
  logic [COUNT_W-1:0]    res_count;
  logic                  res_status;

  logic                  acc;
  logic                  bad;
  logic [SLOT_W-1:0]     slot_in;
  logic [ADDR_W-1:0]     base_rd;
  logic [ADDR_W-1:0]     addr_rd;
  logic [BANK_W-1:0]     bank_idx;
  logic [COUNT_W-1:0]    cnt_cur;
  logic [WEIGHT_W-1:0]   w;
  logic [WEIGHT_W-1:0]   n;
  logic [WEIGHT_W-1:0]   wnew;
  logic                  fin_load;
  logic                  sweep_last;

  logic                  t_we;
  logic [ADDR_W-1:0]     t_waddr;
  logic [PIX_FW-1:0]     t_wdata;
  logic [PIX_FW-1:0]     trd;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  assign cfg.ready  = 1'b1;
  assign item.ready = (state == ST_IDLE);
  assign acc        = item.valid && item.ready;

  assign bad = (32'(item.bank) >= BANKS) || (32'(item.class_index) >= CLASSES) ||
               (32'(item.pixel_index) >= PIXELS);
  assign slot_in = SLOT_W'(32'(item.bank) * CLASSES + 32'(item.class_index));

  assign base_rd  = ADDR_W'(32'(slot_r) * PIXELS);
  assign addr_rd  = base_rd + ADDR_W'(pix_r);
  assign bank_idx = BANK_W'(bank_r);
  assign cnt_cur  = cnt[bank_idx];

  assign w    = nz[slot_r] ? wrd : '0;
  assign n    = (w < weight_cap) ? w : weight_cap;
  assign wnew = (last_r && (w != WEIGHT_MAX)) ? w + 1'b1 : w;

  assign fin_load   = (state == ST_FIN) && (!res_valid || result.ready);
  assign sweep_last = (pix_cnt == PIX_W'(PIXELS - 1));

  // template RAM write port
  always_comb begin
    t_we    = 1'b0;
    t_waddr = addr_r;
    t_wdata = pin_r;
    case (state)
      ST_CLEAR, ST_SWEEP: begin
        t_we    = 1'b1;
        t_waddr = addr_cnt;
        t_wdata = rom_pixel(CLASS_FW'(cls_cnt), ROM_PIX_W'(pix_cnt));
      end
      ST_CALC: begin
        t_we = (cmd_r == CMD_LEARN) && (w == '0);
      end
      ST_DIV: begin
        t_we    = div_rsp.done;
        t_wdata = div_rsp.quotient;
      end
      default: ;
    endcase
  end

  assign w_we = ((state == ST_CALC) && (cmd_r == CMD_LEARN) && (w == '0) && last_r) ||
                ((state == ST_DIV) && div_rsp.done);
  assign w_wdata = (state == ST_DIV) ? pend_weight : WEIGHT_W'(1);

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[slot_r] <= w_wdata;
    end
    wrd <= wmem[slot_r];
  end

  assign div_req = '{start: (state == ST_MUL),
                     dividend: prod + DIVIDEND_W'(pin_r),
                     divisor: dvs_r};

  tsral_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tsral_tmem #(.DEPTH(DEPTH)) u_tmem (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (addr_rd),
    .rdata (trd)
  );

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      weight_cap <= WEIGHT_CAP_RST;
      addr_cnt   <= '0;
      pix_cnt    <= '0;
      cls_cnt    <= '0;
      nz         <= '0;
      res_valid  <= 1'b0;
      for (int i = 0; i < BANKS; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        weight_cap <= cfg.data;
      end

      if (fin_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      if ((state == ST_CLEAR) || (state == ST_SWEEP)) begin
        addr_cnt <= addr_cnt + 1'b1;
        if (sweep_last) begin
          pix_cnt <= '0;
          cls_cnt <= (cls_cnt == CLS_W'(CLASSES - 1)) ? '0 : cls_cnt + 1'b1;
        end else begin
          pix_cnt <= pix_cnt + 1'b1;
        end
      end

      case (state)
        ST_CLEAR: begin
          if (addr_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc) begin
            state <= bad ? ST_FIN : ST_READ;
          end
        end
        ST_READ: begin
          addr_cnt <= base_rd;
          pix_cnt  <= '0;
          cls_cnt  <= CLS_W'(cls_r);
          state    <= ST_CALC;
        end
        ST_CALC: begin
          case (cmd_r)
            CMD_LEARN: begin
              if (w == '0) begin
                if (last_r) begin
                  nz[slot_r]    <= 1'b1;
                  cnt[bank_idx] <= cnt_cur + 1'b1;
                end
                state <= ST_FIN;
              end else begin
                state <= ST_MUL;
              end
            end
            CMD_RESET: begin
              if (nz[slot_r]) begin
                nz[slot_r]    <= 1'b0;
                cnt[bank_idx] <= cnt_cur - 1'b1;
              end
              state <= ST_SWEEP;
            end
            default: begin
              state <= ST_FIN;
            end
          endcase
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= ST_FIN;
          end
        end
        ST_SWEEP: begin
          if (sweep_last) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // transaction payload and pending result
  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r  <= item.cmd;
      bank_r <= item.bank;
      cls_r  <= item.class_index;
      pix_r  <= item.pixel_index;
      pin_r  <= item.pixel_in;
      last_r <= item.last_pixel;
      slot_r <= slot_in;
      if (bad) begin
        pend_pixel  <= '0;
        pend_weight <= '0;
        pend_count  <= '0;
        pend_status <= 1'b1;
      end
    end

    if (state == ST_READ) begin
      addr_r <= addr_rd;
    end

    if (state == ST_CALC) begin
      pend_status <= 1'b0;
      pend_pixel  <= trd;
      pend_weight <= w;
      pend_count  <= cnt_cur;
      case (cmd_r)
        CMD_LEARN: begin
          if (w == '0) begin
            pend_pixel <= pin_r;
            if (last_r) begin
              pend_weight <= WEIGHT_W'(1);
              pend_count  <= cnt_cur + 1'b1;
            end
          end else begin
            prod        <= DIVIDEND_W'(trd) * DIVIDEND_W'(n);
            dvs_r       <= DIVISOR_W'(n) + 1'b1;
            pend_weight <= wnew;
          end
        end
        CMD_RESET: begin
          pend_pixel  <= rom_pixel(cls_r, ROM_PIX_W'(pix_r));
          pend_weight <= '0;
          if (nz[slot_r]) begin
            pend_count <= cnt_cur - 1'b1;
          end
        end
        default: ;
      endcase
    end

    if ((state == ST_DIV) && div_rsp.done) begin
      pend_pixel <= div_rsp.quotient;
    end

    if (fin_load) begin
      res_pixel  <= pend_pixel;
      res_weight <= pend_weight;
      res_count  <= pend_count;
      res_status <= pend_status;
    end
  end

  assign result.valid         = res_valid;
  assign result.pixel_out     = res_pixel;
  assign result.weight_out    = res_weight;
  assign result.learned_count = res_count;
  assign result.status        = res_status;

  `TSRAL_ASSERT_IMP(a_reject_zero, result.valid && result.status, (result.pixel_out == '0) && (result.weight_out == '0) && (result.learned_count == '0), "rejected transaction carries data")
  `TSRAL_ASSERT_IMP(a_count_range, result.valid, 32'(result.learned_count) <= CLASSES, "learned count above class count")
  `TSRAL_ASSERT_NXT(a_busy_after_accept, item.valid && item.ready, !item.ready, "transaction taken while busy")
  `TSRAL_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")

endmodule

// ----- rtl/tsral_div.sv -----
module tsral_div (
  input  logic                clk,
  input  logic                rst,
  input  tsral_pkg::div_req_t req,
  output tsral_pkg::div_rsp_t rsp
);
  import tsral_pkg::*;

  localparam int STEPS  = QUOT_W;
  localparam int STEP_W = $clog2(STEPS);

  logic                  busy;
  logic                  done;
  logic [STEP_W-1:0]     step;
  logic [DIVIDEND_W-1:0] rem;
  logic [DIVIDEND_W-1:0] ds;
  logic [QUOT_W-1:0]     q;
  logic                  ge;
  logic [DIVIDEND_W-1:0] diff;

  // restoring division, one quotient bit per cycle, msb first
  assign ge   = rem >= ds;
  assign diff = rem - ds;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend;
      ds  <= DIVIDEND_W'(req.divisor) << (QUOT_W - 1);
      q   <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= diff;
      end
      ds <= ds >> 1;
      q  <= {q[QUOT_W-2:0], ge};
    end
  end

  assign rsp = '{busy: busy, done: done, quotient: q};

endmodule

// ----- rtl/tsral_tmem.sv -----
module tsral_tmem #(
  parameter int DEPTH = tsral_pkg::BANKS_DEF * tsral_pkg::CLASSES_DEF * tsral_pkg::PIXELS_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic [tsral_pkg::PIX_FW-1:0]  wdata,
  input  logic [ADDR_W-1:0]             raddr,
  output logic [tsral_pkg::PIX_FW-1:0]  rdata
);
  import tsral_pkg::*;

  logic [PIX_FW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- test/template_store_running_average_learner_core_tb.sv -----
`timescale 1ns / 1ps

module template_store_running_average_learner_core_tb;
  import tsral_pkg::*;

  localparam int BANKS   = BANKS_DEF;
  localparam int CLASSES = CLASSES_DEF;
  localparam int PIXELS  = PIXELS_DEF;

  localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ_ALT = 2'd3;
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam int PHASE_ITEMS   = 238;
  localparam int SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 2_500_000;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [BANK_FW-1:0]  bank;
    logic [CLASS_FW-1:0] class_index;
    logic [PIX_FW-1:0]   pixel_index;
    logic [PIX_FW-1:0]   pixel_in;
    logic                last_pixel;
  } item_t;

  typedef struct packed {
    logic [PIX_FW-1:0]   pixel;
    logic [WEIGHT_W-1:0] weight;
    logic [COUNT_W-1:0]  count;
    logic                status;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } plan_row_t;

  localparam result_t UNTYPED = '0;
  localparam int PLAN_LEN = 22;

  logic clk = 1'b0;
  logic rst;

  tsral_cfg_if cfg_ch();
  tsral_in_if  item_ch();
  tsral_out_if result_ch();

  template_store_running_average_learner_core #(
    .BANKS  (BANKS),
    .CLASSES(CLASSES),
    .PIXELS (PIXELS)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .item  (item_ch),
    .result(result_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state
  logic [PIX_FW-1:0]   tmpl_pixels [BANKS*CLASSES*PIXELS];
  logic [WEIGHT_W-1:0] class_weights [BANKS*CLASSES];
  logic [WEIGHT_W-1:0] weight_cap;

  result_t pending_results [$];
  int errors = 0;
  bit quiet = 1'b0;
  int unsigned cycle_count = 0;

  plan_row_t directed_rows [PLAN_LEN] = '{
    '{'{CMD_READ,     3'd0, 4'd0,  8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0,   16'd0, 5'd0, STATUS_DONE}},
    '{'{CMD_READ,     3'd7, 4'd9,  8'd255, 8'd0,   1'b0}, 1'b1, '{8'd193, 16'd0, 5'd0, STATUS_DONE}},
    '{'{CMD_READ_ALT, 3'd3, 4'd5,  8'd16,  8'd0,   1'b0}, 1'b1, '{8'd14,  16'd0, 5'd0, STATUS_DONE}},
    '{'{CMD_READ,     3'd0, 4'd10, 8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0, 16'd0, 5'd0, STATUS_REJECT}},
    '{'{CMD_LEARN,    3'd7, 4'd15, 8'd255, 8'd255, 1'b1}, 1'b1, '{8'd0, 16'd0, 5'd0, STATUS_REJECT}},
    '{'{CMD_RESET,    3'd4, 4'd12, 8'd7,   8'd0,   1'b0}, 1'b1, '{8'd0, 16'd0, 5'd0, STATUS_REJECT}},
    '{'{CMD_LEARN,    3'd0, 4'd0,  8'd0,   8'd255, 1'b0}, 1'b1, '{8'd255, 16'd0, 5'd0, STATUS_DONE}},
    '{'{CMD_LEARN,    3'd0, 4'd0,  8'd1,   8'd0,   1'b1}, 1'b1, '{8'd0,   16'd1, 5'd1, STATUS_DONE}},
    '{'{CMD_LEARN,    3'd0, 4'd0,  8'd0,   8'd0,   1'b0}, 1'b1, '{8'd127, 16'd1, 5'd1, STATUS_DONE}},
    '{'{CMD_LEARN,    3'd0, 4'd0,  8'd0,   8'd255, 1'b1}, 1'b1, '{8'd191, 16'd2, 5'd1, STATUS_DONE}},
    '{'{CMD_LEARN,    3'd0, 4'd0,  8'd0,   8'd0,   1'b0}, 1'b0, UNTYPED},
    '{'{CMD_LEARN,    3'd7, 4'd9,  8'd200, 8'd77,  1'b1}, 1'b1, '{8'd77,  16'd1, 5'd1, STATUS_DONE}},
    '{'{CMD_LEARN,    3'd7, 4'd9,  8'd200, 8'd0,   1'b1}, 1'b0, UNTYPED},
    '{'{CMD_LEARN,    3'd7, 4'd0,  8'd255, 8'd255, 1'b1}, 1'b1, '{8'd255, 16'd1, 5'd2, STATUS_DONE}},
    '{'{CMD_READ,     3'd0, 4'd0,  8'd0,   8'd0,   1'b0}, 1'b0, UNTYPED},
    '{'{CMD_RESET,    3'd0, 4'd0,  8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0,   16'd0, 5'd0, STATUS_DONE}},
    '{'{CMD_READ,     3'd0, 4'd0,  8'd1,   8'd0,   1'b0}, 1'b1, '{8'd7,   16'd0, 5'd0, STATUS_DONE}},
    '{'{CMD_RESET,    3'd7, 4'd9,  8'd200, 8'd0,   1'b0}, 1'b1, '{8'd25,  16'd0, 5'd1, STATUS_DONE}},
    '{'{CMD_LEARN,    3'd5, 4'd3,  8'd128, 8'd170, 1'b1}, 1'b1, '{8'd170, 16'd1, 5'd1, STATUS_DONE}},
    '{'{CMD_LEARN,    3'd5, 4'd3,  8'd128, 8'd85,  1'b1}, 1'b0, UNTYPED},
    '{'{CMD_LEARN,    3'd2, 4'd9,  8'd127, 8'd1,   1'b0}, 1'b0, UNTYPED},
    '{'{CMD_READ_ALT, 3'd0, 4'd10, 8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0, 16'd0, 5'd0, STATUS_REJECT}}
  };

  function automatic logic [PIX_FW-1:0] default_pixel(input int unsigned cls,
                                                      input int unsigned pix);
    return PIX_FW'(cls * 29 + pix * 7 + (pix >> 4) * 13);
  endfunction

  function automatic void reload_class(input int unsigned slot, input int unsigned cls);
    for (int unsigned p = 0; p < PIXELS; p++)
      tmpl_pixels[slot*PIXELS + p] = default_pixel(cls, p);
    class_weights[slot] = '0;
  endfunction

  function automatic result_t apply_item(input item_t it);
    result_t r;
    int unsigned slot, addr, n, acc, learned;
    logic [WEIGHT_W-1:0] w;
    r = '0;
    if (it.bank >= BANKS || it.class_index >= CLASSES || it.pixel_index >= PIXELS) begin
      r.status = STATUS_REJECT;
      return r;
    end
    slot = it.bank * CLASSES + it.class_index;
    addr = slot * PIXELS + it.pixel_index;
    case (it.cmd)
      CMD_LEARN: begin
        w = class_weights[slot];
        if (w == '0) begin
          tmpl_pixels[addr] = it.pixel_in;
          if (it.last_pixel) class_weights[slot] = 16'd1;
        end else begin
          n = 32'((w < weight_cap) ? w : weight_cap);
          acc = 32'(tmpl_pixels[addr]) * n + 32'(it.pixel_in);
          tmpl_pixels[addr] = PIX_FW'(acc / (n + 1));
          if (it.last_pixel && w != WEIGHT_MAX) class_weights[slot] = w + 16'd1;
        end
      end
      CMD_RESET: reload_class(slot, it.class_index);
      default: ;
    endcase
    learned = 0;
    for (int c = 0; c < CLASSES; c++)
      if (class_weights[it.bank*CLASSES + c] != '0) learned++;
    r.pixel  = tmpl_pixels[addr];
    r.weight = class_weights[slot];
    r.count  = COUNT_W'(learned);
    r.status = STATUS_DONE;
    return r;
  endfunction

  function automatic int idle_cycles();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_item(input item_t it, input logic typed, input result_t want);
    int gap;
    result_t predicted;
    gap = idle_cycles();
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.cmd         <= it.cmd;
    item_ch.bank        <= it.bank;
    item_ch.class_index <= it.class_index;
    item_ch.pixel_index <= it.pixel_index;
    item_ch.pixel_in    <= it.pixel_in;
    item_ch.last_pixel  <= it.last_pixel;
    do @(posedge clk); while (!item_ch.ready);
    predicted = apply_item(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_cap(input logic [WEIGHT_W-1:0] value);
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    weight_cap = value;
  endtask

  // Mostly whole patches into a few hot classes, so weights climb past the cap.
  task automatic random_phase(input int count);
    item_t it;
    int sent, kind, len;
    bit broken;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 39) == 0) quiet = ~quiet;
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 9) < 7) begin
        it.bank        = BANK_FW'($urandom_range(0, 1));
        it.class_index = CLASS_FW'($urandom_range(0, 3));
      end else begin
        it.bank        = BANK_FW'($urandom_range(0, BANKS - 1));
        it.class_index = CLASS_FW'($urandom_range(0, CLASSES - 1));
      end
      it.pixel_index = PIX_FW'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                    : $urandom_range(0, 255));
      it.pixel_in    = PIX_FW'($urandom_range(0, 255));
      it.last_pixel  = 1'($urandom_range(0, 1));
      if (kind < 60) begin
        len = $urandom_range(1, 6);
        broken = ($urandom_range(0, 9) == 0);
        it.cmd = CMD_LEARN;
        for (int k = 0; k < len; k++) begin
          it.pixel_index = PIX_FW'($urandom_range(0, 3) != 0 ? $urandom_range(0, 15)
                                                             : $urandom_range(0, 255));
          it.pixel_in    = PIX_FW'($urandom_range(0, 255));
          it.last_pixel  = (k == len - 1) && !broken;
          push_item(it, 1'b0, UNTYPED);
          sent++;
        end
      end else if (kind < 78) begin
        it.cmd = CMD_W'($urandom_range(CMD_READ, CMD_READ_ALT));
        push_item(it, 1'b0, UNTYPED);
        sent++;
      end else if (kind < 82) begin
        it.cmd = CMD_RESET;
        push_item(it, 1'b0, UNTYPED);
        sent++;
      end else if (kind < 92) begin
        it.cmd         = CMD_W'($urandom_range(CMD_LEARN, CMD_READ_ALT));
        it.class_index = CLASS_FW'($urandom_range(CLASSES, 15));
        push_item(it, 1'b0, UNTYPED);
        sent++;
      end else begin
        it.cmd = CMD_LEARN;
        push_item(it, 1'b0, UNTYPED);
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: pixel_out %0d weight_out %0d",
               result_ch.pixel_out, result_ch.weight_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result_ch.pixel_out !== want.pixel) begin
          $error("pixel_out: expected %0d, got %0d", want.pixel, result_ch.pixel_out);
          errors++;
        end
        if (result_ch.weight_out !== want.weight) begin
          $error("weight_out: expected %0d, got %0d", want.weight, result_ch.weight_out);
          errors++;
        end
        if (result_ch.learned_count !== want.count) begin
          $error("learned_count: expected %0d, got %0d", want.count, result_ch.learned_count);
          errors++;
        end
        if (result_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_ch.status);
          errors++;
        end
      end
    end
  end

  initial begin : result_stalls
    int n;
    do @(posedge clk); while (rst);
    forever begin
      n = idle_cycles();
      if (n != 0) begin
        result_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("template_store_running_average_learner_core verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [WEIGHT_W-1:0] caps [6];
    rst                 <= 1'b1;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.data         <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.cmd         <= CMD_LEARN;
    item_ch.bank        <= '0;
    item_ch.class_index <= '0;
    item_ch.pixel_index <= '0;
    item_ch.pixel_in    <= '0;
    item_ch.last_pixel  <= 1'b0;
    result_ch.ready     <= 1'b0;
    for (int s = 0; s < BANKS*CLASSES; s++) reload_class(s, s % CLASSES);
    weight_cap = WEIGHT_CAP_RST;
    caps = '{16'd1, WEIGHT_MAX, 16'd0, 16'd2, WEIGHT_CAP_RST, 16'($urandom_range(3, 300))};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      push_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

    foreach (caps[ph]) begin
      drain_results();
      write_cap(caps[ph]);
      random_phase(PHASE_ITEMS / 2);
      drain_results();
      random_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors += pending_results.size();
    end
    if (errors == 0)
      $display("template_store_running_average_learner_core verification clean");
    else
      $display("template_store_running_average_learner_core verification failed");
    $finish;
  end

endmodule
